// ===== hw/rtl/sbi_pkg.sv =====
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types and constants for the stack bytecode interpreter.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int VIDX_W   = 5;
    localparam int STATUS_W = 2;

    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [OP_W-1:0] {
        OP_LIT = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_GET = 3'd5,
        OP_SET = 3'd6,
        OP_END = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic div_run;
    } sbi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic end_blocked;
        logic div_done;
    } sbi_sts_t;

endpackage

// ===== hw/rtl/sbi_if.sv =====
// ----------------------------------------------------------------------------
// sbi_if
// Valid/ready channels: instruction in, result out.
// ----------------------------------------------------------------------------
interface sbi_in_if;
    import sbi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] literal;
    logic [VIDX_W-1:0]        var_index;

    modport source (output valid, output op, output literal, output var_index, input ready);
    modport sink   (input valid, input op, input literal, input var_index, output ready);
endinterface

interface sbi_out_if;
    import sbi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/sbi_ram.sv =====
// ----------------------------------------------------------------------------
// sbi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/sbi_div.sv =====
// ----------------------------------------------------------------------------
// sbi_div
// Signed 32-bit divider, radix 2, one quotient bit per cycle, truncating
// toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module sbi_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sbi_pkg::data_t dividend,
    input  sbi_pkg::data_t divisor,
    output logic          done,
    output sbi_pkg::data_t quotient
);
    import sbi_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic               busy_reg;
    logic               fix_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    data_t              rem_reg;
    data_t              quo_reg;
    data_t              dsr_reg;
    logic               neg_reg;
    data_t              res_reg;
    logic [DATA_W:0]    rem_sh;
    logic [DATA_W:0]    trial;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DATA_W-1]};
        trial  = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fix_reg;
            fix_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_W-1] ? data_t'(-dividend) : dividend;
            dsr_reg <= divisor[DATA_W-1] ? data_t'(-divisor) : divisor;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[DATA_W] ? rem_sh[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
        end
        if (fix_reg)
        begin
            res_reg <= neg_reg ? data_t'(-quo_reg) : quo_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// ===== hw/rtl/sbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbi_ctrl
// Sequencer: fetch an instruction, execute it, wait on the divider.
// ----------------------------------------------------------------------------
module sbi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output sbi_pkg::sbi_cmd_t cmd,
    input  sbi_pkg::sbi_sts_t sts
);
    import sbi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_div)
                begin
                    state_next = S_DIV;
                end
                else if (!sts.end_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.load    = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.div_run = (state_reg == S_DIV);

endmodule

// ===== hw/rtl/sbi_datapath.sv =====
// ----------------------------------------------------------------------------
// sbi_datapath
// Operand stack (top cached in a register), variable store, ALU, divider
// and result register.
// ----------------------------------------------------------------------------
module sbi_datapath #(
    parameter int STACK_DEPTH    = 1024,
    parameter int VARIABLE_COUNT = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sbi_pkg::sbi_cmd_t                  cmd,
    output sbi_pkg::sbi_sts_t                  sts,
    input  logic [sbi_pkg::OP_W-1:0]           op,
    input  logic signed [sbi_pkg::DATA_W-1:0]  literal,
    input  logic [sbi_pkg::VIDX_W-1:0]         var_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sbi_pkg::DATA_W-1:0]  value,
    output logic [sbi_pkg::STATUS_W-1:0]       status
);
    import sbi_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VAW  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    // control state
    logic [SP_W-1:0]           sp_reg, sp_next;
    status_t                   err_reg, err_next;
    logic [VARIABLE_COUNT-1:0] vvalid_reg, vvalid_next;
    logic                      out_valid_reg, out_valid_next;

    // payload
    opcode_t                   op_reg;
    data_t                     lit_reg;
    logic [VIDX_W-1:0]         idx_reg;
    data_t                     tos_reg, tos_next;
    data_t                     value_reg, value_next;
    status_t                   status_reg, status_next;

    logic                      stk_we;
    logic [SAW-1:0]            stk_waddr;
    logic [SAW-1:0]            stk_raddr;
    data_t                     stk_rdata;
    logic                      var_we;
    logic [VAW-1:0]            var_sel;
    data_t                     var_rdata;

    logic [SP_W-1:0]           sp_m1;
    logic [SP_W-1:0]           sp_m2;
    logic                      sp_ge2;
    logic                      sp_empty;
    logic                      sp_full;
    logic                      var_in_rng;
    logic                      var_hit;
    data_t                     push_val;
    data_t                     alu_res;
    logic                      div_start;
    logic                      div_done;
    data_t                     div_q;

    function automatic status_t flag(input status_t cur, input status_t code);
        flag = (cur == ST_OK) ? code : cur;
    endfunction

    assign sp_m1      = sp_reg - SP_W'(1);
    assign sp_m2      = sp_reg - SP_W'(2);
    assign sp_ge2     = (sp_reg >= SP_W'(2));
    assign sp_empty   = (sp_reg == '0);
    assign sp_full    = (sp_reg == SP_FULL);
    assign stk_waddr  = sp_m1[SAW-1:0];
    assign stk_raddr  = sp_m2[SAW-1:0];
    assign var_sel    = VAW'(idx_reg);
    assign var_in_rng = (int'(idx_reg) < VARIABLE_COUNT);
    assign var_hit    = var_in_rng && vvalid_reg[var_sel];
    assign push_val   = (op_reg == OP_LIT) ? lit_reg : (var_hit ? var_rdata : '0);

    always_comb
    begin
        case (op_reg)
            OP_SUB:  alu_res = stk_rdata - tos_reg;
            OP_MUL:  alu_res = stk_rdata * tos_reg;
            default: alu_res = stk_rdata + tos_reg;
        endcase
    end

    assign sts.need_div    = cmd.exec && (op_reg == OP_DIV) && sp_ge2 && (tos_reg != '0);
    assign sts.end_blocked = (op_reg == OP_END) && out_valid_reg && !out_ready;
    assign sts.div_done    = div_done;

    always_comb
    begin
        sp_next        = sp_reg;
        err_next       = err_reg;
        vvalid_next    = vvalid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tos_next       = tos_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        stk_we         = 1'b0;
        var_we         = 1'b0;
        div_start      = 1'b0;
        if (cmd.exec)
        begin
            unique case (op_reg) inside
                OP_LIT, OP_GET:
                begin
                    if (sp_full)
                    begin
                        err_next = flag(err_reg, ST_OVERFLOW);
                    end
                    else
                    begin
                        stk_we   = !sp_empty;
                        tos_next = push_val;
                        sp_next  = sp_reg + SP_W'(1);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (!sp_ge2)
                    begin
                        err_next = flag(err_reg, ST_UNDERFLOW);
                    end
                    else
                    begin
                        tos_next = alu_res;
                        sp_next  = sp_m1;
                    end
                end
                OP_DIV:
                begin
                    if (!sp_ge2)
                    begin
                        err_next = flag(err_reg, ST_UNDERFLOW);
                    end
                    else if (tos_reg == '0)
                    begin
                        err_next = flag(err_reg, ST_DIVZERO);
                        tos_next = '0;
                        sp_next  = sp_m1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                OP_SET:
                begin
                    if (sp_empty)
                    begin
                        err_next = flag(err_reg, ST_UNDERFLOW);
                    end
                    else if (var_in_rng)
                    begin
                        var_we               = 1'b1;
                        vvalid_next[var_sel] = 1'b1;
                    end
                end
                OP_END:
                begin
                    if (!sts.end_blocked)
                    begin
                        out_valid_next = 1'b1;
                        value_next     = sp_empty ? '0 : tos_reg;
                        status_next    = sp_empty ? flag(err_reg, ST_UNDERFLOW) : err_reg;
                        sp_next        = '0;
                        err_next       = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.div_run && div_done)
        begin
            tos_next = div_q;
            sp_next  = sp_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            vvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            vvalid_reg    <= vvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(op);
            lit_reg <= data_t'(literal);
            idx_reg <= var_index;
        end
        tos_reg    <= tos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    sbi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (tos_reg),
        .re    (cmd.load),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VARIABLE_COUNT)
    ) u_var_ram (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_sel),
        .wdata (tos_reg),
        .re    (cmd.load),
        .raddr (VAW'(var_index)),
        .rdata (var_rdata)
    );

    sbi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stk_rdata),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

// ===== hw/rtl/stack_bytecode_interpreter.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_interpreter
// Executes one stack bytecode instruction per instr transaction; END returns
// the top of stack and the program status on the result channel.
//
//   channel   dir   payload                      notes
//   instr     in    op, literal, var_index       one instruction
//   result    out   value, status                one per END
//
// Every instruction is accepted (stack and variable RAM reads issued), then
// executed. DIV with a nonzero divisor then waits on the radix-2 divider
// (start, 32 iterations, sign fix and handoff).
// END waits in execute while the result register is full and not taken;
// other instructions proceed while a result is pending.
// Reset empties the stack, clears the status and marks all variables zero
// through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_bytecode_interpreter #(
    parameter int STACK_DEPTH    = 1024,
    parameter int VARIABLE_COUNT = 26
) (
    input  logic      clk,
    input  logic      rst_n,
    sbi_in_if.sink    instr,
    sbi_out_if.source result
);
    import sbi_pkg::*;

    sbi_cmd_t cmd;
    sbi_sts_t sts;

    sbi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sbi_datapath #(
        .STACK_DEPTH    (STACK_DEPTH),
        .VARIABLE_COUNT (VARIABLE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (instr.op),
        .literal   (instr.literal),
        .var_index (instr.var_index),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .value     (result.value),
        .status    (result.status)
    );

endmodule

// ===== hw/rtl/sbi_checker.sv =====
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks for the stack bytecode interpreter.
// ----------------------------------------------------------------------------
module sbi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [sbi_pkg::OP_W-1:0]          in_op,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [sbi_pkg::DATA_W-1:0] out_value,
    input logic [sbi_pkg::STATUS_W-1:0]      out_status
);
    import sbi_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
        else $error("result changed while stalled");

    // instructions are never accepted back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instruction accepted in consecutive cycles");

    // non-divide, non-end instructions return to ready after accept and execute
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op != OP_DIV && in_op != OP_END |-> ##2 in_ready)
        else $error("instruction did not finish in two cycles");

    // a new result follows an END transaction
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_op == OP_END, 2))
        else $error("result without END");

endmodule

bind stack_bytecode_interpreter sbi_checker u_sbi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (instr.valid),
    .in_ready   (instr.ready),
    .in_op      (instr.op),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.value),
    .out_status (result.status)
);
